// ===== sv/lou_pkg.sv =====
// shared constants and types for the logic-op execute unit
package lou_pkg;

  // sizes; arena size and index reach are powers of two
  localparam int ARENA_BYTES = 4096;
  localparam int INDEX_REACH = 512;
  localparam int REG_COUNT   = 16;

  localparam int AW      = $clog2(ARENA_BYTES);
  localparam int ROWS    = ARENA_BYTES / 4;
  localparam int ROW_W   = AW - 2;
  localparam int RIW     = $clog2(REG_COUNT);
  localparam int CLR_LEN = (ROWS > REG_COUNT) ? ROWS : REG_COUNT;
  localparam int CLR_W   = $clog2(CLR_LEN);

  localparam logic [31:0] REACH_MASK = 32'(INDEX_REACH - 1);

  // opcodes
  localparam logic [2:0] OP_AND     = 3'd0;
  localparam logic [2:0] OP_OR      = 3'd1;
  localparam logic [2:0] OP_XOR     = 3'd2;
  localparam logic [2:0] OP_WR_BYTE = 3'd3;
  localparam logic [2:0] OP_WR_REG  = 3'd4;

  // operand kinds
  localparam logic [1:0] KIND_REG = 2'd1;
  localparam logic [1:0] KIND_DIR = 2'd2;
  localparam logic [1:0] KIND_IND = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [1:0]         type_a;
    logic signed [31:0] value_a;
    logic [1:0]         type_b;
    logic signed [31:0] value_b;
    logic [4:0]         dest_reg;
    logic [11:0]        pc;
    logic [11:0]        write_addr;
    logic [7:0]         write_byte;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               carry_out;
    logic               bad_register;
  } rsp_t;

  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          wr_all;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
  } arena_cmd_t;

  typedef struct packed {
    logic           re;
    logic [RIW-1:0] ra0;
    logic [RIW-1:0] ra1;
    logic           we;
    logic [RIW-1:0] wa;
    logic [31:0]    wd;
  } rf_cmd_t;

endpackage

// ===== sv/lou_if.sv =====
// request and response channel interfaces
interface lou_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [1:0]         type_a;
  logic signed [31:0] value_a;
  logic [1:0]         type_b;
  logic signed [31:0] value_b;
  logic [4:0]         dest_reg;
  logic [11:0]        pc;
  logic [11:0]        write_addr;
  logic [7:0]         write_byte;

  modport source (
    output valid, opcode, type_a, value_a, type_b, value_b, dest_reg, pc,
           write_addr, write_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, type_a, value_a, type_b, value_b, dest_reg, pc,
           write_addr, write_byte,
    output ready
  );
endinterface

interface lou_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               carry_out;
  logic               bad_register;

  modport source (output valid, result, carry_out, bad_register, input ready);
  modport sink (input valid, result, carry_out, bad_register, output ready);
endinterface

// ===== sv/lou_arena.sv =====
// byte arena in four byte-lane banks, one unaligned 32-bit big-endian read per cycle without a write
module lou_arena import lou_pkg::*; (
  input  logic       clk,
  input  arena_cmd_t cmd,
  output logic [31:0] rd_word
);

  logic [7:0] bank_q [4];
  logic [1:0] lsb_q;

  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0]       mem [ROWS];
    logic [7:0]       bq;
    logic [ROW_W-1:0] rd_row;
    logic             we;

    // lanes below the start lane hold bytes of the next row
    assign rd_row = cmd.rd_addr[AW-1:2] +
                    ((2'(j) < cmd.rd_addr[1:0]) ? ROW_W'(1) : ROW_W'(0));
    assign we = cmd.wr_en && (cmd.wr_all || cmd.wr_addr[1:0] == 2'(j));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[cmd.wr_addr[AW-1:2]] <= cmd.wr_data;
      end else if (cmd.rd_en) begin
        bq <= mem[rd_row];
      end
    end

    assign bank_q[j] = bq;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      lsb_q <= cmd.rd_addr[1:0];
    end
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < 4; i++) begin
      rd_word[31-8*i -: 8] = bank_q[lsb_q + 2'(i)];
    end
  end

endmodule

// ===== sv/lou_regfile.sv =====
// register file, two registered read ports and one write port
module lou_regfile import lou_pkg::*; (
  input  logic        clk,
  input  rf_cmd_t     cmd,
  output logic [31:0] q0,
  output logic [31:0] q1
);

  logic [31:0] mem [REG_COUNT];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.wa] <= cmd.wd;
    end
    if (cmd.re) begin
      q0 <= mem[cmd.ra0];
      q1 <= mem[cmd.ra1];
    end
  end

endmodule

// ===== sv/logic_op_execute_unit_top.sv =====
// top level: and/or/xor execute unit with arena and register file
//
// Requests come in on req (valid/ready) and one response per request leaves
// on rsp (valid/ready). A request carries an opcode (and, or, xor, arena byte
// write, register write), two operands with their kinds, a destination
// register, pc and the byte-write address and data.
// Each request passes issue states S_OP_A and S_OP_B: operand A's arena
// word is read in the first, operand B's word and both register reads in
// the second, since all arena reads share one read port per byte lane.
// The cycle after that computes the result and writes the register file
// and carry; the response is valid in the cycle after. A new request can
// be taken as the previous one leaves issue.
// After reset the block zeroes the arena and registers in a clearing
// pass, with req.ready low. Carry resets to zero. Responses wait in a
// two-entry queue; while the receiver stalls and the queue is full, a
// request waits in S_OP_B until there is room, holding req.ready low.
module logic_op_execute_unit_top import lou_pkg::*; (
  input  logic clk,
  input  logic rst,
  lou_req_if.sink   req,
  lou_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_OP_A  = 4'b0100,
    S_OP_B  = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CLR_W-1:0] clr_cnt;
  req_t             iss, ex;
  logic             ex_valid;
  logic [31:0]      opa_mem;
  logic             carry;

  rsp_t             fifo [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       fifo_cnt;

  logic             pop, advance, accept;
  logic [2:0]       cnt_after;
  logic [31:0]      opnd_val, wr_addr32;
  logic [AW-1:0]    opnd_addr;
  arena_cmd_t       arena_cmd;
  rf_cmd_t          rf_cmd;
  logic [31:0]      arena_word, rf_q0, rf_q1;

  logic [31:0]      a_val, b_val, res, dest32;
  logic             ok_a, ok_b, dest_ok, ex_we, carry_we, carry_new, bad;
  rsp_t             item;

  function automatic logic [AW-1:0] ind_addr(input logic [11:0] pc_in,
                                             input logic [31:0] v);
    logic [31:0] mag, rem, off, sum;
    mag = v[31] ? (~v + 32'd1) : v;
    rem = mag & REACH_MASK;
    off = v[31] ? (~rem + 32'd1) : rem;
    sum = {20'd0, pc_in} + off;
    return sum[AW-1:0];
  endfunction

  function automatic logic reg_ok(input logic signed [31:0] v);
    return (v >= 32'sd1) && (v <= 32'(REG_COUNT));
  endfunction

  function automatic logic [RIW-1:0] reg_idx(input logic [31:0] v);
    logic [31:0] m;
    m = v - 32'd1;
    return m[RIW-1:0];
  endfunction

  // handshake and flow control
  assign pop       = (fifo_cnt != 2'd0) && rsp.ready;
  assign cnt_after = 3'(fifo_cnt) + 3'(ex_valid) - 3'(pop);
  assign advance   = (state == S_OP_B) && (cnt_after < 3'd2);
  assign req.ready = (state == S_IDLE) || advance;
  assign accept    = req.valid && req.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (32'(clr_cnt) == 32'(CLR_LEN - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_OP_A;
      end
      S_OP_A: state_next = S_OP_B;
      S_OP_B: begin
        if (advance) state_next = accept ? S_OP_A : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + CLR_W'(1);
    end
  end

  // shared indirect address unit: operand a in the first issue cycle, b in the second
  assign opnd_val  = (state == S_OP_B) ? iss.value_b : iss.value_a;
  assign opnd_addr = ind_addr(iss.pc, opnd_val);
  assign wr_addr32 = {20'd0, iss.write_addr};

  always_comb begin
    arena_cmd = '0;
    case (state)
      S_CLEAR: begin
        arena_cmd.wr_en   = 32'(clr_cnt) < 32'(ROWS);
        arena_cmd.wr_all  = 1'b1;
        arena_cmd.wr_addr = {clr_cnt[ROW_W-1:0], 2'b00};
      end
      S_OP_A: begin
        if (iss.opcode == OP_WR_BYTE) begin
          arena_cmd.wr_en   = 1'b1;
          arena_cmd.wr_addr = wr_addr32[AW-1:0];
          arena_cmd.wr_data = iss.write_byte;
        end else begin
          arena_cmd.rd_en   = 1'b1;
          arena_cmd.rd_addr = opnd_addr;
        end
      end
      S_OP_B: begin
        // read only on the way out so operand a's word stays put while stalled
        arena_cmd.rd_en   = advance;
        arena_cmd.rd_addr = opnd_addr;
      end
      default: arena_cmd = '0;
    endcase
  end

  always_comb begin
    rf_cmd     = '0;
    rf_cmd.re  = advance;
    rf_cmd.ra0 = reg_ok(iss.value_a) ? reg_idx(iss.value_a) : '0;
    rf_cmd.ra1 = reg_ok(iss.value_b) ? reg_idx(iss.value_b) : '0;
    if (state == S_CLEAR) begin
      rf_cmd.we = 32'(clr_cnt) < 32'(REG_COUNT);
      rf_cmd.wa = clr_cnt[RIW-1:0];
      rf_cmd.wd = '0;
    end else begin
      rf_cmd.we = ex_we;
      rf_cmd.wa = reg_idx(dest32);
      rf_cmd.wd = res;
    end
  end

  lou_arena u_arena (
    .clk     (clk),
    .cmd     (arena_cmd),
    .rd_word (arena_word)
  );

  lou_regfile u_regfile (
    .clk (clk),
    .cmd (rf_cmd),
    .q0  (rf_q0),
    .q1  (rf_q1)
  );

  // execute: arena word b and register reads arrive here
  assign dest32  = {27'd0, ex.dest_reg};
  assign dest_ok = (dest32 >= 32'd1) && (dest32 <= 32'(REG_COUNT));
  assign ok_a    = (ex.type_a != KIND_REG) || reg_ok(ex.value_a);
  assign ok_b    = (ex.type_b != KIND_REG) || reg_ok(ex.value_b);

  always_comb begin
    case (ex.type_a)
      KIND_REG: a_val = rf_q0;
      KIND_IND: a_val = opa_mem;
      default:  a_val = ex.value_a;
    endcase
    case (ex.type_b)
      KIND_REG: b_val = rf_q1;
      KIND_IND: b_val = arena_word;
      default:  b_val = ex.value_b;
    endcase
  end

  always_comb begin
    res       = '0;
    bad       = 1'b0;
    carry_we  = 1'b0;
    carry_new = 1'b0;
    ex_we     = 1'b0;
    case (ex.opcode) inside
      OP_AND, OP_OR, OP_XOR: begin
        if (dest_ok && ok_a && ok_b) begin
          case (ex.opcode)
            OP_AND:  res = a_val & b_val;
            OP_OR:   res = a_val | b_val;
            default: res = a_val ^ b_val;
          endcase
          ex_we     = ex_valid;
          carry_we  = 1'b1;
          carry_new = (res == 32'd0);
        end else begin
          bad = 1'b1;
        end
      end
      OP_WR_REG: begin
        if (dest_ok) begin
          res   = ex.value_a;
          ex_we = ex_valid;
        end else begin
          bad = 1'b1;
        end
      end
      default: res = '0;
    endcase
    item.result       = res;
    item.carry_out    = carry_we ? carry_new : carry;
    item.bad_register = bad;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      iss <= '{opcode: req.opcode, type_a: req.type_a, value_a: req.value_a,
               type_b: req.type_b, value_b: req.value_b, dest_reg: req.dest_reg,
               pc: req.pc, write_addr: req.write_addr, write_byte: req.write_byte};
    end
    if (advance) begin
      ex      <= iss;
      opa_mem <= arena_word;
    end
    if (ex_valid) begin
      fifo[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
      carry    <= 1'b0;
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fifo_cnt <= 2'd0;
    end else begin
      ex_valid <= advance;
      if (ex_valid && carry_we) carry <= carry_new;
      if (ex_valid) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fifo_cnt <= fifo_cnt + 2'(ex_valid) - 2'(pop);
    end
  end

  assign rsp.valid        = (fifo_cnt != 2'd0);
  assign rsp.result       = fifo[rd_ptr].result;
  assign rsp.carry_out    = fifo[rd_ptr].carry_out;
  assign rsp.bad_register = fifo[rd_ptr].bad_register;

  // every request leaving issue is executed in the next cycle
  a_adv_ex: assert property (@(posedge clk) disable iff (rst) advance |=> ex_valid)
    else $error("issued request did not reach execute");

  // execute never pushes into a full response queue
  a_no_ovf: assert property (@(posedge clk) disable iff (rst)
    ex_valid |-> (fifo_cnt < 2'd2 || pop))
    else $error("response queue overflow");

  // no request is taken while memories are being cleared
  a_clr_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request taken during clearing pass");

  // register reads never coincide with a write-back, so no forwarding is needed
  a_rf_hazard: assert property (@(posedge clk) disable iff (rst)
    rf_cmd.re |-> !ex_valid)
    else $error("register read overlaps write-back");

endmodule
